/* sv/cartridge_multi_game_bank_mapper_assert.svh */
// Assertion macros shared by the bank mapper RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef CARTRIDGE_MULTI_GAME_BANK_MAPPER_ASSERT_SVH
`define CARTRIDGE_MULTI_GAME_BANK_MAPPER_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define CMGBM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define CMGBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/cmgbm_pkg.sv */
// Types and constants for the multi-game cartridge bank mapper.
// No dependencies; imported by cmgbm_decode and the top level.
`default_nettype none

package cmgbm_pkg;

  // Configuration port geometry: one 32-bit register at byte address 0
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic CFG_IDX_CART_HAS_RAM = 1'b0;

  // Memory target of one access
  typedef enum logic [2:0] {
    TK_FLAT = 3'd0,
    TK_ROM  = 3'd1,
    TK_RAM  = 3'd2,
    TK_ZERO = 3'd3,
    TK_NONE = 3'd4
  } target_kind_t;

  // One CPU bus access
  typedef struct packed {
    logic        is_write;
    logic [15:0] addr;
    logic [7:0]  data;
  } access_t;

  // Mapper control state
  typedef struct packed {
    logic       mode_set;
    logic [4:0] rom_base_bank;
    logic [4:0] rom_switch_bank;
    logic       ram_enabled;
    logic [1:0] ram_bank_sel;
  } mapper_state_t;

  // One translated access
  typedef struct packed {
    target_kind_t kind;
    logic [5:0]   bank_index;
    logic [15:0]  mem_offset;
    logic         ram_write_strobe;
  } map_result_t;

endpackage

`default_nettype wire

/* sv/cartridge_multi_game_bank_mapper.sv */
// Top level of the multi-game cartridge bank mapper: stage register, decode, result register.
// Depends on cmgbm_pkg, cmgbm_decode and cartridge_multi_game_bank_mapper_assert.svh.
//
//   channel   | handshake              | payload
//   ----------+------------------------+------------------------------------------------
//   in_       | in_valid / in_ready    | req_type, bus_address, write_byte
//   out_      | out_valid / out_ready  | target_kind, bank_index, mem_offset, ram_write_strobe
//   cfg (APB) | psel, penable, pready  | pwrite, paddr, pwdata, prdata
//
// Each beat crosses stage then result register; one beat per cycle while out_ready is high.
// The decode path (a 5-bit add and range compares) sits between the stage register and
// the result register; mapper state updates as a beat moves into the result register.
// rst_n is synchronous; it empties both registers and clears mapper state and cart_has_ram.
// A stalled result holds its beat; the stage register still takes one more input beat.
`default_nettype none
`include "cartridge_multi_game_bank_mapper_assert.svh"

module cartridge_multi_game_bank_mapper
  import cmgbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [15:0]           in_bus_address,
  input  logic [7:0]            in_write_byte,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_target_kind,
  output logic [5:0]            out_bank_index,
  output logic [15:0]           out_mem_offset,
  output logic                  out_ram_write_strobe,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic          s_valid_r;
  access_t       s_acc_r;
  logic          out_valid_r;
  map_result_t   out_res_r;
  mapper_state_t state_r;
  mapper_state_t state_nxt;
  logic          cart_has_ram_r;
  map_result_t   dec_res;
  logic          advance;
  logic          cfg_wr;

  // Handshake: move the staged beat when the result register is free or draining
  assign advance  = s_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s_valid_r || advance;

  cmgbm_decode u_decode (
    .acc          (s_acc_r),
    .st           (state_r),
    .cart_has_ram (cart_has_ram_r),
    .res          (dec_res),
    .st_nxt       (state_nxt)
  );

  // Configuration access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_CART_HAS_RAM);
  assign prdata = (psel && paddr[2] == CFG_IDX_CART_HAS_RAM) ?
                  {{(APB_DATA_W-1){1'b0}}, cart_has_ram_r} : '0;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r      <= 1'b0;
      out_valid_r    <= 1'b0;
      state_r        <= '0;
      cart_has_ram_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        cart_has_ram_r <= pwdata[0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_acc_r <= '{is_write: in_req_type, addr: in_bus_address, data: in_write_byte};
    end
    if (advance) begin
      out_res_r <= dec_res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_target_kind      = out_res_r.kind;
  assign out_bank_index       = out_res_r.bank_index;
  assign out_mem_offset       = out_res_r.mem_offset;
  assign out_ram_write_strobe = out_res_r.ram_write_strobe;

  // Checks
  `CMGBM_ASSERT_SAME(a_strobe_is_ram, out_valid_r && out_res_r.ram_write_strobe, out_res_r.kind == TK_RAM, "strobe on non-RAM result")
  `CMGBM_ASSERT_NEXT(a_mode_sticky, state_r.mode_set, state_r.mode_set, "mode flag cleared")
  `CMGBM_ASSERT_SAME(a_premode_clear, !state_r.mode_set, state_r.rom_switch_bank == 5'd0 && !state_r.ram_enabled && state_r.ram_bank_sel == 2'd0, "bank state moved before mode set")
  `CMGBM_ASSERT_NEXT(a_advance_fills, advance, out_valid_r, "advanced beat lost")
  `CMGBM_ASSERT_SAME(a_stall_means_full, !in_ready, s_valid_r && out_valid_r, "input stalled with room")

endmodule

`default_nettype wire

/* sv/cmgbm_decode.sv */
// Address decode and control-register update for one bus access.
// Depends on cmgbm_pkg; purely combinational.
`default_nettype none

module cmgbm_decode
  import cmgbm_pkg::*;
(
  input  access_t       acc,
  input  mapper_state_t st,
  input  logic          cart_has_ram,
  output map_result_t   res,
  output mapper_state_t st_nxt
);

  logic in_rom_lo;    // 0000-3FFF
  logic in_rom_hi;    // 4000-7FFF
  logic in_ram;       // A000-BFFF
  logic in_ctl_en;    // 0000-1FFF
  logic in_ctl_bank;  // 2000-3FFF
  logic in_ctl_ram;   // 4000-5FFF
  logic [5:0] rom_sum;
  logic ram_store;

  // Classify the address
  assign in_rom_lo   = (acc.addr[15:14] == 2'b00);
  assign in_rom_hi   = (acc.addr[15:14] == 2'b01);
  assign in_ram      = (acc.addr[15:13] == 3'b101);
  assign in_ctl_en   = (acc.addr[15:13] == 3'b000);
  assign in_ctl_bank = (acc.addr[15:13] == 3'b001);
  assign in_ctl_ram  = (acc.addr[15:13] == 3'b010);

  assign rom_sum   = {1'b0, st.rom_base_bank} + {1'b0, st.rom_switch_bank};
  assign ram_store = acc.is_write && in_ram && cart_has_ram && st.ram_enabled;

  // Build the result beat
  always_comb begin
    res = '{kind: TK_FLAT, bank_index: '0, mem_offset: acc.addr, ram_write_strobe: 1'b0};
    if (acc.is_write) begin
      if (ram_store) begin
        res.kind             = TK_RAM;
        res.bank_index       = {4'd0, st.ram_bank_sel};
        res.mem_offset       = {3'd0, acc.addr[12:0]};
        res.ram_write_strobe = 1'b1;
      end else begin
        res.kind       = TK_NONE;
        res.mem_offset = '0;
      end
    end else if (in_rom_lo) begin
      if (st.mode_set) begin
        res.kind       = TK_ROM;
        res.bank_index = {1'b0, st.rom_base_bank};
      end
    end else if (in_rom_hi) begin
      if (st.mode_set) begin
        res.kind       = TK_ROM;
        res.bank_index = rom_sum;
        res.mem_offset = {2'd0, acc.addr[13:0]};
      end
    end else if (in_ram) begin
      res.mem_offset = {3'd0, acc.addr[12:0]};
      if (st.ram_enabled) begin
        res.kind       = TK_RAM;
        res.bank_index = {4'd0, st.ram_bank_sel};
      end else begin
        res.kind = TK_ZERO;
      end
    end
  end

  // Update control state on writes to the control ranges
  always_comb begin
    st_nxt = st;
    if (acc.is_write) begin
      if (in_ctl_en) begin
        if (!st.mode_set) begin
          st_nxt.mode_set = 1'b1;
        end else begin
          st_nxt.ram_enabled = cart_has_ram && (acc.data[3:0] == 4'hA);
        end
      end else if (in_ctl_bank) begin
        if (!st.mode_set) begin
          st_nxt.rom_base_bank = acc.data[4:0];
        end else begin
          st_nxt.rom_switch_bank = acc.data[4:0];
        end
      end else if (in_ctl_ram && st.mode_set) begin
        st_nxt.ram_bank_sel = acc.data[1:0];
      end
    end
  end

endmodule

`default_nettype wire
